// ===== design/lpfc_pkg.sv =====
// shared types, constants and the crc byte update for the frame checker
`timescale 1ns / 1ps

package lpfc_pkg;

  localparam logic [7:0]  StartByte      = 8'h7E;
  localparam logic [15:0] CrcPoly        = 16'h1021;
  localparam logic [7:0]  MaxLengthReset = 8'd250;
  localparam logic [7:0]  MinLength      = 8'd3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CRC_CHECK_EN = 1'b0,
    REG_MAX_LENGTH   = 1'b1
  } lpfc_reg_e;

  // receive phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } lpfc_phase_e;

  // frame status reported with each word
  typedef enum logic [1:0] {
    ST_NOT_LAST = 2'd0,
    ST_GOOD     = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_LEN_ERR  = 2'd3
  } lpfc_status_e;

  typedef struct packed {
    logic       crc_check_en;
    logic [7:0] len_limit;
  } lpfc_cfg_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic [7:0]   byte_index;
    logic         last;
    lpfc_status_e status;
    logic [15:0]  computed_crc;
  } lpfc_res_t;

  // crc-16 0x1021, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/lpfc_if.sv =====
// valid/ready channel interfaces for incoming bytes and result words
`timescale 1ns / 1ps

interface lpfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic        last;
  logic [1:0]  status;
  logic [15:0] computed_crc;

  modport source (output valid, output data_byte, output byte_index, output last,
                  output status, output computed_crc, input ready);
  modport sink   (input valid, input data_byte, input byte_index, input last,
                  input status, input computed_crc, output ready);
endinterface

// ===== design/lpfc_cfg.sv =====
// configuration registers of the frame checker
`timescale 1ns / 1ps

module lpfc_cfg import lpfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output lpfc_cfg_t  cfg_o
);

  lpfc_cfg_t cfg_q;

  // register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_check_en <= 1'b1;
      cfg_q.len_limit    <= MaxLengthReset;
    end else if (cfg_we_i) begin
      case (lpfc_reg_e'(cfg_idx_i))
        REG_CRC_CHECK_EN: cfg_q.crc_check_en <= cfg_wdata_i[0];
        REG_MAX_LENGTH:   cfg_q.len_limit    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lpfc_frame.sv =====
// framing state, crc update and result word build for one byte
`timescale 1ns / 1ps

module lpfc_frame import lpfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lpfc_cfg_t  cfg_i,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       has_res_o,
  output lpfc_res_t  res_o
);

  lpfc_phase_e phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  rcl_q, rcl_d;

  logic [8:0]  idx_p1;
  logic [8:0]  idx_p2;
  logic [15:0] rx_crc;

  assign idx_p1 = {1'b0, count_q} + 9'd1;
  assign idx_p2 = {1'b0, count_q} + 9'd2;
  assign rx_crc = {byte_i, rcl_q};

  // next state and result for the byte in the input register
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    len_d     = len_q;
    crc_d     = crc_q;
    rcl_d     = rcl_q;
    has_res_o = 1'b0;
    res_o     = '{data_byte: byte_i, byte_index: 8'd0, last: 1'b0,
                  status: ST_NOT_LAST, computed_crc: 16'd0};
    case (phase_q)
      PH_LEN: begin
        has_res_o = 1'b1;
        if (byte_i < MinLength || byte_i > cfg_i.len_limit) begin
          phase_d      = PH_HUNT;
          res_o.last   = 1'b1;
          res_o.status = ST_LEN_ERR;
        end else begin
          len_d   = byte_i;
          crc_d   = crc_byte(16'd0, byte_i);
          count_d = 8'd1;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        has_res_o        = 1'b1;
        res_o.byte_index = count_q;
        if (idx_p1 >= {1'b0, len_q}) begin
          // final byte: high half of the received crc
          phase_d            = PH_HUNT;
          res_o.last         = 1'b1;
          res_o.computed_crc = crc_q;
          res_o.status       = (cfg_i.crc_check_en && rx_crc != crc_q) ? ST_CRC_ERR : ST_GOOD;
        end else begin
          if (idx_p2 == {1'b0, len_q}) begin
            rcl_d = byte_i;
          end else begin
            crc_d = crc_byte(crc_q, byte_i);
          end
          count_d = idx_p1[7:0];
        end
      end
      default: begin
        // hunting for the start byte
        phase_d = PH_HUNT;
        if (byte_i == StartByte) begin
          phase_d = PH_LEN;
          count_d = 8'd0;
          crc_d   = 16'd0;
        end
      end
    endcase
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= 8'd0;
      len_q   <= 8'd0;
      crc_q   <= 16'd0;
      rcl_q   <= 8'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rcl_q   <= rcl_d;
    end
  end

endmodule

// ===== design/length_prefixed_frame_crc_checker_unit.sv =====
// Length-prefixed frame checker with CRC-16 (poly 0x1021, init 0, msb first).
// Bytes are dropped until the start byte 0x7E; the next byte is the frame
// length (counting itself) and must lie between 3 and the length limit
// register, else a single length-error word is returned. Every frame byte
// comes out as one word with its index; the last word carries the computed
// crc and the good / crc-error status (the received crc is the last two
// bytes, low byte first). Throughput is one byte per clock while result words
// are taken as they are offered: a byte sits in the input register while the
// framing logic and one-byte crc update run, and its word is then loaded into
// the output register. A new byte can enter an empty input register while a
// finished word waits to be taken; a byte whose word cannot be loaded stays.
`timescale 1ns / 1ps

module length_prefixed_frame_crc_checker_unit import lpfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpfc_in_if.sink     byte_in_i,
  lpfc_out_if.source  result_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  lpfc_cfg_t  cfg;
  lpfc_res_t  res;
  logic       has_res;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  lpfc_res_t  out_res_q;

  logic out_free;
  logic take;
  logic load_out;
  logic in_accept;

  // pipeline control
  assign out_free  = !out_valid_q || result_o.ready;
  assign take      = in_valid_q && (!has_res || out_free);
  assign load_out  = take && has_res;
  assign byte_in_i.ready = !in_valid_q || take;
  assign in_accept = byte_in_i.valid && byte_in_i.ready;

  lpfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lpfc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .byte_i    (in_byte_q),
    .take_i    (take),
    .has_res_o (has_res),
    .res_o     (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_in_i.ready) begin
      in_valid_q <= byte_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= byte_in_i.rx_byte;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= load_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.data_byte    = out_res_q.data_byte;
  assign result_o.byte_index   = out_res_q.byte_index;
  assign result_o.last         = out_res_q.last;
  assign result_o.status       = out_res_q.status;
  assign result_o.computed_crc = out_res_q.computed_crc;

endmodule
